// File: rtl/edt_pkg.sv
// Types and codes shared by the duplicate suppression table.
// Used by edt_cell, the top level and the port checker. No dependencies.
package edt_pkg;

    // Request type codes on the input item
    localparam logic [1:0] REQ_REPORT = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // Operation carried by the token that walks the cell row
    localparam logic [1:0] OP_NONE    = 2'd0;
    localparam logic [1:0] OP_REPORT  = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 1'd1;

    localparam logic [7:0] HOLD_RESET  = 8'd12;
    localparam logic [7:0] COUNT_MAX   = 8'hFF;

    // Input item
    typedef struct packed {
        logic [1:0]  req_type;
        logic [47:0] source_address;
    } req_t;

    // Result item
    typedef struct packed {
        logic       ignored;
        logic       is_new;
        logic [7:0] repeat_count;
        logic [5:0] slot_index;
        logic       replaced_full;
        logic       any_aging;
    } rsp_t;

    // Token handed from cell to cell
    typedef struct packed {
        logic        vld;
        logic [1:0]  op;
        logic        ign;
        logic [47:0] addr;
        logic        matched;
        logic        have_free;
        logic        running;
        logic [7:0]  count;
    } tok_t;

    // Insert command broadcast to all cells after a report misses
    typedef struct packed {
        logic        vld;
        logic [47:0] addr;
        logic [7:0]  hold;
    } ins_t;

endpackage

// File: rtl/event_dedup_table_with_aging_top.sv
// Top level of the duplicate suppression table with aging.
// Row of edt_cell slots, token launch, result registers, config registers.
// Depends on edt_pkg and edt_cell.
//
// Channel  Handshake              Payload
// req      req_valid / req_stall  edt_pkg::req_t  (req_type, source_address)
// rsp      rsp_valid / rsp_stall  edt_pkg::rsp_t  (one result per item)
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (cfg_ready always high)
//
// An item's token is registered at launch, then passes one cell per cycle
// along the row of slots; its result is registered as it leaves the last.
// One item is in the row at a time; req_stall is high while it is there,
// so a new item is taken only once the last one has left the row.
// Reset empties the table at once through the per-slot valid bits.
// A waiting result does not block the next item; a second is parked.
module event_dedup_table_with_aging_top #(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  edt_pkg::req_t                       req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output edt_pkg::rsp_t                       rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [edt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [7:0]                          cfg_data
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic             scan_enable_reg;
    logic [7:0]       hold_ticks_reg;
    logic             busy_reg;
    edt_pkg::tok_t    launch_reg;
    logic             out_valid_reg;
    edt_pkg::rsp_t    out_reg;
    logic             pend_valid_reg;
    edt_pkg::rsp_t    pend_reg;

    edt_pkg::tok_t    tok      [0:TABLE_ENTRIES];
    logic [IDX_W-1:0] hit_idx  [0:TABLE_ENTRIES];
    logic [IDX_W-1:0] free_idx [0:TABLE_ENTRIES];

    edt_pkg::tok_t    fin;
    edt_pkg::rsp_t    res;
    edt_pkg::ins_t    ins;
    logic [IDX_W-1:0] ins_idx;
    logic             req_take;
    logic             out_take;
    edt_pkg::tok_t    launch_next;

    assign req_take  = req_valid && !req_stall;
    assign out_take  = out_valid_reg && !rsp_stall;
    assign req_stall = busy_reg || pend_valid_reg;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_enable_reg <= 1'b1;
            hold_ticks_reg  <= edt_pkg::HOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                edt_pkg::REG_SCAN_ENABLE: scan_enable_reg <= cfg_data[0];
                edt_pkg::REG_HOLD_TICKS:  hold_ticks_reg  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // turn the input item into a token
    always_comb
    begin
        launch_next      = '0;
        launch_next.vld  = req_take;
        launch_next.addr = req.source_address;
        case (req.req_type)
            edt_pkg::REQ_REPORT:
            begin
                launch_next.op  = scan_enable_reg ? edt_pkg::OP_REPORT : edt_pkg::OP_NONE;
                launch_next.ign = !scan_enable_reg;
            end
            edt_pkg::REQ_TICK:  launch_next.op = edt_pkg::OP_TICK;
            edt_pkg::REQ_CLEAR: launch_next.op = edt_pkg::OP_CLEAR;
            default:            launch_next.op = edt_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            launch_reg <= '0;
        else
            launch_reg <= launch_next;
    end

    // row of slots
    assign tok[0]      = launch_reg;
    assign hit_idx[0]  = '0;
    assign free_idx[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        edt_cell #(
            .IDX_W   (IDX_W),
            .CELL_ID (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .tok_in       (tok[g]),
            .hit_idx_in   (hit_idx[g]),
            .free_idx_in  (free_idx[g]),
            .tok_out      (tok[g+1]),
            .hit_idx_out  (hit_idx[g+1]),
            .free_idx_out (free_idx[g+1]),
            .ins          (ins),
            .ins_idx      (ins_idx)
        );
    end

    // result and insert from the token leaving the last slot
    assign fin = tok[TABLE_ENTRIES];

    always_comb
    begin
        res      = '0;
        ins      = '0;
        ins.addr = fin.addr;
        ins.hold = hold_ticks_reg;
        ins_idx  = '0;
        case (fin.op)
            edt_pkg::OP_REPORT:
            begin
                if (fin.matched)
                begin
                    res.repeat_count = fin.count;
                    res.slot_index   = 6'(hit_idx[TABLE_ENTRIES]);
                end
                else
                begin
                    // lowest free slot, or slot 0 when full
                    ins_idx           = fin.have_free ? free_idx[TABLE_ENTRIES] : '0;
                    ins.vld           = fin.vld;
                    res.is_new        = 1'b1;
                    res.replaced_full = !fin.have_free;
                    res.slot_index    = 6'(ins_idx);
                end
            end
            edt_pkg::OP_TICK: res.any_aging = fin.running;
            edt_pkg::OP_NONE: res.ignored   = fin.ign;
            default:          ;
        endcase
    end

    // busy flag and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_take)
                busy_reg <= 1'b1;
            else if (fin.vld)
                busy_reg <= 1'b0;

            if (fin.vld)
            begin
                if (!out_valid_reg || out_take)
                    out_valid_reg <= 1'b1;
                else
                    pend_valid_reg <= 1'b1;
            end
            else if (pend_valid_reg && (!out_valid_reg || out_take))
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin.vld)
        begin
            if (!out_valid_reg || out_take)
                out_reg <= res;
            else
                pend_reg <= res;
        end
        else if (pend_valid_reg && (!out_valid_reg || out_take))
            out_reg <= pend_reg;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// File: rtl/edt_cell.sv
// One table slot: valid bit, address, hold timer and repeat count.
// Processes the passing token and hands it to the next cell. Uses edt_pkg.
module edt_cell #(
    parameter int unsigned IDX_W   = 6,
    parameter int unsigned CELL_ID = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  edt_pkg::tok_t    tok_in,
    input  logic [IDX_W-1:0] hit_idx_in,
    input  logic [IDX_W-1:0] free_idx_in,
    output edt_pkg::tok_t    tok_out,
    output logic [IDX_W-1:0] hit_idx_out,
    output logic [IDX_W-1:0] free_idx_out,
    input  edt_pkg::ins_t    ins,
    input  logic [IDX_W-1:0] ins_idx
);

    localparam logic [IDX_W-1:0] MY_ID = IDX_W'(CELL_ID);

    logic             valid_reg, valid_next;
    logic [47:0]      addr_reg, addr_next;
    logic [7:0]       timer_reg, timer_next;
    logic [7:0]       count_reg, count_next;
    logic [7:0]       count_inc;
    edt_pkg::tok_t    tok_reg, tok_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    // saturating repeat count
    assign count_inc = (count_reg == edt_pkg::COUNT_MAX) ? count_reg : count_reg + 8'd1;

    // slot update and token hand-off
    always_comb
    begin
        valid_next    = valid_reg;
        addr_next     = addr_reg;
        timer_next    = timer_reg;
        count_next    = count_reg;
        tok_next      = tok_in;
        hit_idx_next  = hit_idx_in;
        free_idx_next = free_idx_in;

        if (ins.vld && ins_idx == MY_ID)
        begin
            valid_next = 1'b1;
            addr_next  = ins.addr;
            timer_next = ins.hold;
            count_next = 8'd0;
        end
        else if (tok_in.vld)
        begin
            case (tok_in.op)
                edt_pkg::OP_REPORT:
                begin
                    if (!tok_in.matched)
                    begin
                        if (valid_reg && addr_reg == tok_in.addr)
                        begin
                            count_next       = count_inc;
                            tok_next.matched = 1'b1;
                            tok_next.count   = count_inc;
                            hit_idx_next     = MY_ID;
                        end
                        else if (!valid_reg && !tok_in.have_free)
                        begin
                            // lowest free slot seen so far
                            tok_next.have_free = 1'b1;
                            free_idx_next      = MY_ID;
                        end
                    end
                end
                edt_pkg::OP_TICK:
                begin
                    if (valid_reg)
                    begin
                        if (timer_reg == 8'd0)
                            valid_next = 1'b0;
                        else
                        begin
                            timer_next       = timer_reg - 8'd1;
                            tok_next.running = 1'b1;
                        end
                    end
                end
                edt_pkg::OP_CLEAR:
                begin
                    valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // slot payload and token indexes
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        timer_reg    <= timer_next;
        count_reg    <= count_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    assign tok_out      = tok_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;

endmodule

// File: rtl/edt_checker.sv
// Port checker for the duplicate suppression table, bound to the top level.
// Depends on edt_pkg and event_dedup_table_with_aging_top.
module edt_port_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input edt_pkg::rsp_t rsp
);

    // a dropped report carries nothing else
    a_ignored_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.ignored |-> !rsp.is_new && rsp.repeat_count == 8'd0 &&
            rsp.slot_index == 6'd0 && !rsp.replaced_full && !rsp.any_aging)
        else $error("ignored item with other fields set");

    // a new entry starts with count zero and is no tick result
    a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_new |-> rsp.repeat_count == 8'd0 && !rsp.any_aging)
        else $error("new entry with nonzero count");

    // replacement only ever hits slot 0 of a new entry
    a_replace_slot0: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.replaced_full |-> rsp.is_new && rsp.slot_index == 6'd0)
        else $error("full-table replacement not at slot 0");

    // one item in the table at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second item accepted while busy");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

endmodule

bind event_dedup_table_with_aging_top edt_port_checker u_edt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// File: dv/edt_checker.sv
`timescale 1ns / 100ps
// Checker for the duplicate suppression table: watches the request, result and
// config channels, keeps its own copy of the table and compares every result.
// Depends on edt_pkg.
module edt_checker
    import edt_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_stall,
    input  req_t                 req,
    input  logic                 rsp_valid,
    input  logic                 rsp_stall,
    input  rsp_t                 rsp,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output int unsigned          fail_count,
    output int unsigned          pending,
    output int unsigned          n_checked
);

    // Shadow copy of the table and the registers
    logic        slot_valid [TABLE_ENTRIES];
    logic [47:0] slot_addr  [TABLE_ENTRIES];
    logic [7:0]  slot_timer [TABLE_ENTRIES];
    logic [7:0]  slot_count [TABLE_ENTRIES];
    logic        scan_on;
    logic [7:0]  hold_load;

    // Results owed by the block, oldest first
    rsp_t due_results [$];

    // Empty every slot of the shadow table
    function automatic void wipe_slots();
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_addr[i]  = '0;
            slot_timer[i] = '0;
            slot_count[i] = '0;
        end
    endfunction

    // Update the shadow table for one item and return the result it causes
    function automatic rsp_t apply_request(input req_t item);
        rsp_t res;
        int   free_idx;
        logic running;
        res      = '0;
        free_idx = -1;
        running  = 1'b0;
        case (item.req_type)
            REQ_REPORT:
            begin
                if (!scan_on)
                begin
                    res.ignored = 1'b1;
                    return res;
                end
                // lowest matching valid slot wins; remember lowest free slot
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (slot_valid[i] && slot_addr[i] == item.source_address)
                    begin
                        if (slot_count[i] != COUNT_MAX)
                            slot_count[i] = slot_count[i] + 8'd1;
                        res.repeat_count = slot_count[i];
                        res.slot_index   = 6'(i);
                        return res;
                    end
                    if (free_idx < 0 && !slot_valid[i])
                        free_idx = i;
                end
                // full table: slot 0 is overwritten
                if (free_idx < 0)
                begin
                    free_idx          = 0;
                    res.replaced_full = 1'b1;
                end
                slot_valid[free_idx] = 1'b1;
                slot_addr[free_idx]  = item.source_address;
                slot_timer[free_idx] = hold_load;
                slot_count[free_idx] = '0;
                res.is_new           = 1'b1;
                res.slot_index       = 6'(free_idx);
            end
            REQ_TICK:
            begin
                // expired slots are freed, live ones count down
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (slot_valid[i])
                    begin
                        if (slot_timer[i] == 8'd0)
                        begin
                            slot_valid[i] = 1'b0;
                            slot_addr[i]  = '0;
                            slot_count[i] = '0;
                        end
                        else
                        begin
                            slot_timer[i] = slot_timer[i] - 8'd1;
                            running       = 1'b1;
                        end
                    end
                end
                res.any_aging = running;
            end
            REQ_CLEAR:
                wipe_slots();
            default: ;
        endcase
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Sample all channels on the rising edge
    always @(posedge clk or negedge rst_n)
    begin : observe
        rsp_t want;
        if (!rst_n)
        begin
            wipe_slots();
            scan_on    = 1'b1;
            hold_load  = HOLD_RESET;
            fail_count = 0;
            n_checked  = 0;
            due_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SCAN_ENABLE: scan_on   = cfg_data[0];
                    REG_HOLD_TICKS:  hold_load = cfg_data;
                    default: ;
                endcase
            end
            if (req_valid && !req_stall)
                due_results.push_back(apply_request(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result item with nothing outstanding: %h", rsp);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    compare_field("ignored", want.ignored, rsp.ignored);
                    compare_field("is_new", want.is_new, rsp.is_new);
                    compare_field("repeat_count", want.repeat_count, rsp.repeat_count);
                    compare_field("slot_index", want.slot_index, rsp.slot_index);
                    compare_field("replaced_full", want.replaced_full, rsp.replaced_full);
                    compare_field("any_aging", want.any_aging, rsp.any_aging);
                    n_checked++;
                end
            end
        end
        pending = due_results.size();
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Top of the duplicate suppression table testbench: clock, reset, stimulus,
// random idling on both channels and the verdict. Depends on edt_pkg,
// edt_checker and event_dedup_table_with_aging_top.
module testbench;
    import edt_pkg::*;

    localparam int unsigned TABLE_ENTRIES = 64;
    localparam int unsigned ROW_LATENCY   = TABLE_ENTRIES + 2;
    localparam int unsigned CLK_PERIOD    = 12;
    localparam int unsigned RESET_CYCLES  = 6;
    localparam int unsigned ITEM_TARGET   = 1850;
    localparam int unsigned POOL_SIZE     = 40;
    localparam int unsigned STALL_LIMIT   = 40 * (ROW_LATENCY + 2 * 18);
    localparam logic [1:0]  REQ_UNUSED    = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_t                 req_item  = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SCAN_ENABLE;
    logic [7:0]           cfg_data  = '0;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned n_checked;

    // no idling on either side while set
    logic        quiet = 1'b0;
    logic        scan_now = 1'b1;
    logic [47:0] hot_pool [POOL_SIZE];
    int unsigned n_effective = 0;
    int unsigned n_reports = 0;
    int unsigned n_dropped = 0;
    int unsigned n_ticks = 0;
    int unsigned n_clears = 0;
    int unsigned n_unused = 0;
    int unsigned n_settings = 0;
    int unsigned idle_cycles = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    event_dedup_table_with_aging_top #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    edt_checker #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req_item),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .n_checked  (n_checked)
    );

    function automatic logic [47:0] rand_addr();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    // Present one item after a random gap and wait until it is taken
    task automatic send_item(input logic [1:0] kind, input logic [47:0] addr);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= '{req_type: kind, source_address: addr};
        do
            @(posedge clk);
        while (req_stall);
        case (kind)
            REQ_REPORT: n_reports++;
            REQ_TICK:   n_ticks++;
            REQ_CLEAR:  n_clears++;
            default:    n_unused++;
        endcase
        if (kind == REQ_REPORT && !scan_now)
            n_dropped++;
        else
            n_effective++;
    endtask

    // Drop valid and wait until every result has come back
    task automatic wait_idle();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers while the block is idle
    task automatic set_config(input logic scan, input logic [7:0] hold);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_SCAN_ENABLE;
        cfg_data  <= {7'd0, scan};
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= REG_HOLD_TICKS;
        cfg_data  <= hold;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        scan_now = scan;
        n_settings++;
        @(posedge clk);
    endtask

    // One random item: ticks, clears, unused codes and reports over the pool
    task automatic mixed_item(input int unsigned tick_pct, input int unsigned clear_pct,
                              input int unsigned span, input int unsigned fresh_pct);
        int unsigned roll;
        logic [47:0] addr;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < fresh_pct)
            addr = rand_addr();
        else
            addr = hot_pool[$urandom_range(0, span - 1)];
        if (roll < tick_pct)
            send_item(REQ_TICK, addr);
        else if (roll < tick_pct + clear_pct)
            send_item(REQ_CLEAR, addr);
        else if (roll < tick_pct + clear_pct + 2)
            send_item(REQ_UNUSED, addr);
        else
            send_item(REQ_REPORT, addr);
    endtask

    // Result side: random stall before each item is taken
    always
    begin : result_sink
        int unsigned hold;
        hold = quiet ? 0 : $urandom_range(0, 18);
        if (hold != 0)
        begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clk);
        end
        rsp_stall <= 1'b0;
        do
            @(posedge clk);
        while (!rsp_valid);
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", idle_cycles);
            $display("** event_dedup_table_with_aging_top: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned phase_no;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset config, address extremes, duplicates, aging, clear
        send_item(REQ_REPORT, 48'h0);
        send_item(REQ_REPORT, 48'h0);
        send_item(REQ_REPORT, 48'hFFFF_FFFF_FFFF);
        send_item(REQ_REPORT, 48'hAAAA_AAAA_AAAA);
        send_item(REQ_REPORT, 48'h5555_5555_5555);
        send_item(REQ_REPORT, 48'hFFFF_FFFF_FFFF);
        send_item(REQ_TICK, 48'h0);
        send_item(REQ_UNUSED, 48'hFFFF_FFFF_FFFF);
        send_item(REQ_CLEAR, 48'h0);
        send_item(REQ_TICK, 48'h0);
        send_item(REQ_REPORT, 48'h0000_0000_0001);
        // scanning off: reports dropped, ticks and clears still act
        set_config(1'b0, 8'd12);
        send_item(REQ_REPORT, 48'h0000_0000_0001);
        send_item(REQ_TICK, 48'h0);
        send_item(REQ_CLEAR, 48'h0);
        // zero hold time: freed at the next tick
        set_config(1'b1, 8'd0);
        send_item(REQ_REPORT, 48'h0000_0000_0ABC);
        send_item(REQ_REPORT, 48'h0000_0000_0ABC);
        send_item(REQ_TICK, 48'h0);
        send_item(REQ_REPORT, 48'h0000_0000_0ABC);
        set_config(1'b1, 8'd255);
        send_item(REQ_REPORT, 48'h8000_0000_0000);
        send_item(REQ_TICK, 48'h0);
        send_item(REQ_REPORT, 48'hFFFF_FFFF_FFFF);
        send_item(REQ_CLEAR, 48'h0);

        // Random phases
        phase_no = 0;
        while (n_effective < ITEM_TARGET)
        begin
            for (int i = 0; i < POOL_SIZE; i++)
                hot_pool[i] = rand_addr();
            if ($urandom_range(0, 2) == 0)
                hot_pool[$urandom_range(0, POOL_SIZE - 1)] = '0;
            if ($urandom_range(0, 2) == 0)
                hot_pool[$urandom_range(0, POOL_SIZE - 1)] = '1;
            case (phase_no % 5)
                0:
                begin
                    // mixed traffic, moderate hold
                    set_config(1'b1, 8'($urandom_range(1, 24)));
                    quiet = (phase_no % 3 == 2);
                    repeat (150) mixed_item(15, 3, POOL_SIZE, 10);
                end
                1:
                begin
                    // fill past capacity so slot 0 gets replaced
                    set_config(1'b1, 8'($urandom_range(128, 255)));
                    quiet = (phase_no % 3 == 2);
                    send_item(REQ_CLEAR, rand_addr());
                    repeat (110) mixed_item(3, 0, POOL_SIZE, 70);
                end
                2:
                begin
                    // one hot address until its count saturates
                    set_config(1'b1, 8'd255);
                    quiet = (phase_no % 3 == 2);
                    send_item(REQ_CLEAR, rand_addr());
                    repeat (275) mixed_item(0, 0, 1, 3);
                end
                3:
                begin
                    // short hold, frequent ticks: constant expiry and refill
                    set_config(1'b1, 8'($urandom_range(0, 2)));
                    quiet = (phase_no % 3 == 2);
                    repeat (120) mixed_item(35, 2, 8, 10);
                end
                default:
                begin
                    // scanning off
                    set_config(1'b0, 8'($urandom_range(0, 255)));
                    quiet = (phase_no % 3 == 2);
                    repeat (40) mixed_item(15, 3, POOL_SIZE, 20);
                end
            endcase
            phase_no++;
        end

        // Drain, then let the row settle
        wait_idle();
        quiet = 1'b0;
        repeat (ROW_LATENCY + 8) @(posedge clk);
        $display("Run: %0d reports (%0d dropped), %0d ticks, %0d clears, %0d unused codes",
                 n_reports, n_dropped, n_ticks, n_clears, n_unused);
        $display("Run: %0d results checked over %0d register settings", n_checked, n_settings);
        if (fail_count == 0 && pending == 0)
            $display("** event_dedup_table_with_aging_top: PASSED **");
        else
            $display("** event_dedup_table_with_aging_top: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
rtl/edt_pkg.sv
rtl/edt_cell.sv
rtl/event_dedup_table_with_aging_top.sv
rtl/edt_checker.sv
dv/edt_checker.sv
dv/testbench.sv
